[design/zab_pkg.sv]
// Shared types and constants for the address zone bound table.
// No dependencies; imported by the top level and its checker.
package zab_pkg;

  localparam int unsigned ZONE_SLOTS = 64;
  localparam int unsigned IDX_W      = $clog2(ZONE_SLOTS);
  localparam int unsigned CNT_W      = $clog2(ZONE_SLOTS + 1);
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned ADDR_W     = 64;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_AROUND = 2'd2,
    OP_RESET  = 2'd3
  } zab_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT
  } zab_state_e;

  typedef struct packed {
    zab_op_e           opcode;
    logic [KEY_W-1:0]  zone_key;
    logic [ADDR_W-1:0] address;
  } zab_cmd_t;

  typedef struct packed {
    logic             ok;
    logic             prev_found;
    logic [KEY_W-1:0] prev_key;
    logic             next_found;
    logic [KEY_W-1:0] next_key;
  } zab_res_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] low;
    logic [ADDR_W-1:0] high;
  } zab_entry_t;

endpackage

[design/address_zone_bound_table_unit.sv]
// Address zone bound table: ordered zone table held in one synchronous memory.
// Depends on zab_pkg (types, opcodes, table size).
//
// Usage:
//   Command channel: drive cmd_i and raise start_i; the item is taken at a
//   rising edge where start_i is high and busy_o is low. busy_o stays high
//   while the item works through the table.
//   Result channel: res_o is valid for exactly one cycle, marked by
//   res_valid_o. The receiver cannot stall; capture it on that cycle.
//   busy_o is low in the strobe cycle, so the next item may start there.
// Operation:
//   reset, or add with the empty key: the result is strobed in the cycle
//   right after the start edge. add, delete, around: one memory read per
//   cycle over the table, with a registered read (add and delete stop
//   scanning at the first key match; delete then streams the remaining
//   entries back one slot, still one per cycle). The single read port of
//   the zone memory sets this rate.
// Reset: rst_ni clears the zone count and the control state; the memory
//   itself is not cleared, entries at or above the count are never read.
module address_zone_bound_table_unit
  import zab_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  zab_cmd_t cmd_i,
  output logic     busy_o,
  output logic     res_valid_o,
  output zab_res_t res_o
);

  // Zone memory: one write and one registered read per cycle.
  zab_entry_t mem [ZONE_SLOTS];

  logic             we;
  logic [IDX_W-1:0] waddr;
  zab_entry_t       wdata;
  logic             re;
  logic [IDX_W-1:0] raddr;
  zab_entry_t       rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  zab_state_e        state_q, state_d;
  zab_cmd_t          cmd_q, cmd_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              rvalid_q;
  logic [IDX_W-1:0]  ridx_q, ridx_d;
  logic [ADDR_W-1:0] hmark_q, hmark_d, lmark_q, lmark_d;
  logic              pf_q, pf_d, nf_q, nf_d;
  logic [KEY_W-1:0]  pk_q, pk_d, nk_q, nk_d;
  zab_res_t          res_q, res_d;
  logic              res_valid_q, res_valid_d;

  // Scan control shared by all table walks.
  logic issue, drained, hit;
  assign issue   = idx_q < count_q;
  assign drained = !issue && !rvalid_q;
  assign hit     = rvalid_q && (rdata_q.key == cmd_q.zone_key);

  // Around: both tests of each chain evaluated in parallel, then chained
  // by selection. Low bound first, then high bound, as the rule orders them.
  logic n_lo, n_hi, p_lo, p_hi;
  always_comb begin
    n_lo = (rdata_q.low > cmd_q.address) &&
           ((hmark_q == ADDR_ONES) || (rdata_q.low < hmark_q));
    n_hi = (rdata_q.high > cmd_q.address) &&
           (n_lo ? ((rdata_q.low == ADDR_ONES) || (rdata_q.high < rdata_q.low))
                 : ((hmark_q == ADDR_ONES) || (rdata_q.high < hmark_q)));
    p_lo = (rdata_q.low < cmd_q.address) &&
           ((lmark_q == ADDR_ONES) || (rdata_q.low >= lmark_q));
    p_hi = (rdata_q.high <= cmd_q.address) &&
           (p_lo ? ((rdata_q.low == ADDR_ONES) || (rdata_q.high >= rdata_q.low))
                 : ((lmark_q == ADDR_ONES) || (rdata_q.high >= lmark_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rvalid_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rvalid_q    <= re;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload and scan registers: no reset needed.
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    idx_q   <= idx_d;
    ridx_q  <= ridx_d;
    hmark_q <= hmark_d;
    lmark_q <= lmark_d;
    pf_q    <= pf_d;
    pk_q    <= pk_d;
    nf_q    <= nf_d;
    nk_q    <= nk_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    count_d     = count_q;
    ridx_d      = ridx_q;
    hmark_d     = hmark_q;
    lmark_d     = lmark_q;
    pf_d        = pf_q;
    pk_d        = pk_q;
    nf_d        = nf_q;
    nk_d        = nk_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = rdata_q;
    re          = 1'b0;
    raddr       = idx_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          idx_d   = '0;
          hmark_d = ADDR_ONES;
          lmark_d = '0;
          pf_d    = 1'b0;
          pk_d    = '0;
          nf_d    = 1'b0;
          nk_d    = '0;
          res_d   = '0;
          if (cmd_i.opcode == OP_RESET) begin
            // Empty the table at once.
            count_d     = '0;
            res_d.ok    = 1'b1;
            res_valid_d = 1'b1;
          end else if ((cmd_i.opcode == OP_ADD) && (cmd_i.zone_key == '0)) begin
            // Empty name: fail without touching the table.
            res_valid_d = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Advance the read pointer while entries remain.
        if (issue) begin
          re     = 1'b1;
          idx_d  = idx_q + CNT_W'(1);
          ridx_d = idx_q[IDX_W-1:0];
        end
        case (cmd_q.opcode)
          OP_ADD: begin
            if (hit) begin
              // Widen the matched zone in place.
              we          = 1'b1;
              waddr       = ridx_q;
              wdata.key   = rdata_q.key;
              wdata.low   = (cmd_q.address < rdata_q.low) ? cmd_q.address : rdata_q.low;
              wdata.high  = (cmd_q.address > rdata_q.high) ? cmd_q.address : rdata_q.high;
              re          = 1'b0;
              res_d.ok    = 1'b1;
              res_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end else if (drained) begin
              if (count_q < CNT_W'(ZONE_SLOTS)) begin
                // Append a new single-address zone.
                we         = 1'b1;
                waddr      = count_q[IDX_W-1:0];
                wdata.key  = cmd_q.zone_key;
                wdata.low  = cmd_q.address;
                wdata.high = cmd_q.address;
                count_d    = count_q + CNT_W'(1);
                res_d.ok   = 1'b1;
              end
              res_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          OP_DELETE: begin
            if (hit) begin
              state_d = ST_SHIFT;
            end else if (drained) begin
              res_valid_d = 1'b1;
              state_d     = ST_IDLE;
            end
          end
          OP_AROUND: begin
            if (rvalid_q) begin
              if (n_hi) begin
                hmark_d = rdata_q.high;
                nf_d    = 1'b1;
                nk_d    = rdata_q.key;
              end else if (n_lo) begin
                hmark_d = rdata_q.low;
                nf_d    = 1'b1;
                nk_d    = rdata_q.key;
              end
              if (p_hi) begin
                lmark_d = rdata_q.high;
                pf_d    = 1'b1;
                pk_d    = rdata_q.key;
              end else if (p_lo) begin
                lmark_d = rdata_q.low;
                pf_d    = 1'b1;
                pk_d    = rdata_q.key;
              end
            end
            if (drained) begin
              res_d.ok         = 1'b1;
              res_d.prev_found = pf_q;
              res_d.prev_key   = pk_q;
              res_d.next_found = nf_q;
              res_d.next_key   = nk_q;
              res_valid_d      = 1'b1;
              state_d          = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_SHIFT: begin
        // Stream the entries after the deleted one down by one slot.
        if (issue) begin
          re     = 1'b1;
          idx_d  = idx_q + CNT_W'(1);
          ridx_d = idx_q[IDX_W-1:0];
        end
        if (rvalid_q) begin
          we    = 1'b1;
          waddr = ridx_q - IDX_W'(1);
          wdata = rdata_q;
        end
        if (drained) begin
          count_d     = count_q - CNT_W'(1);
          res_d.ok    = 1'b1;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[design/zab_checker.sv]
// Port-level checker for address_zone_bound_table_unit, with its bind.
// Depends on zab_pkg (command and result types, opcodes).
module zab_checker
  import zab_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input zab_cmd_t cmd_i,
  input logic     busy_o,
  input logic     res_valid_o,
  input zab_res_t res_o
);

  // A table walk always raises busy on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (cmd_i.opcode != OP_RESET) &&
     !((cmd_i.opcode == OP_ADD) && (cmd_i.zone_key == '0))) |=> busy_o)
    else $error("table walk did not raise busy");

  // Results come out only when the block is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result strobed while busy");

  // Every end of a walk delivers exactly its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> res_valid_o)
    else $error("walk ended without a result");

  // The previous key is zero unless a previous zone was found.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.prev_found) |-> (res_o.prev_key == '0))
    else $error("previous key set without a previous zone");

  // A failing item never reports neighbors.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.ok) |-> (!res_o.prev_found && !res_o.next_found))
    else $error("failed item reported neighbors");

endmodule

bind address_zone_bound_table_unit zab_checker u_zab_checker (.*);
